/* src/ptom_pkg.sv */
// package for the price-time order matching core
// holds commands, status codes, state type and the cell slot struct
`timescale 1ns / 1ps
package ptom_pkg;

    localparam int BookDepth = 32;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_MODIFY = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DUP_ID    = 3'd1,
        ST_FAK_UNMAT = 3'd2,
        ST_SIDE_FULL = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_SEARCH = 3'd1,
        S_CHECK  = 3'd2,
        S_MATCH  = 3'd3,
        S_REST   = 3'd4,
        S_DONE   = 3'd5
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [31:0] id;
        logic [31:0] price;
        logic [31:0] qty;
    } t_slot;

    // operations broadcast to every cell of one side
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_INSERT = 2'd2,
        OP_SETQ0  = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        is_bid;
        logic [31:0] key_id;
        t_slot       ins;
        logic [31:0] new_qty;
    } t_ctl;

endpackage

/* src/ptom_cell.sv */
// one book slot: holds an order and shifts with its neighbors
// depends on ptom_pkg
`timescale 1ns / 1ps
module ptom_cell
    import ptom_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctl  i_ctl,
    input  logic  i_head,
    input  t_slot i_prev,
    input  t_slot i_next,
    input  logic  i_prev_hit,
    input  logic  i_prev_ins,
    output t_slot o_slot,
    output logic  o_hit,
    output logic  o_ins
);
    t_slot r_slot;
    t_slot n_slot;
    logic  w_match;
    logic  w_after;

    assign o_slot  = r_slot;
    assign w_match = r_slot.valid && (r_slot.id == i_ctl.key_id);
    // hit is sticky down the row: true from the matching cell on
    assign o_hit   = i_prev_hit || w_match;
    // new order goes before the first slot that it beats
    assign w_after = i_ctl.is_bid ? (r_slot.price < i_ctl.ins.price)
                                  : (r_slot.price > i_ctl.ins.price);
    assign o_ins   = i_prev_ins || !r_slot.valid || w_after;

    always_comb begin
        n_slot = r_slot;
        case (i_ctl.op)
            OP_REMOVE: begin
                if (o_hit) begin
                    n_slot = i_next;
                end
            end
            OP_INSERT: begin
                if (i_prev_ins) begin
                    n_slot = i_prev;
                end else if (o_ins) begin
                    n_slot = i_ctl.ins;
                end
            end
            OP_SETQ0: begin
                if (i_head) begin
                    n_slot.qty = i_ctl.new_qty;
                end
            end
            default: begin
                n_slot = r_slot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
        r_slot.id    <= n_slot.id;
        r_slot.price <= n_slot.price;
        r_slot.qty   <= n_slot.qty;
    end
endmodule

/* src/ptom_side.sv */
// one side of the book as a row of cells
// depends on ptom_pkg and ptom_cell
`timescale 1ns / 1ps
module ptom_side
    import ptom_pkg::*;
#(
    parameter int BOOK_DEPTH = BookDepth
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctl  i_ctl,
    output t_slot o_head,
    output logic  o_found,
    output logic  o_full
);
    t_slot w_slot [BOOK_DEPTH];
    logic  w_hit  [BOOK_DEPTH];
    logic  w_ins  [BOOK_DEPTH];
    t_slot w_empty;

    assign w_empty = '0;

    for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
        ptom_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (i_ctl),
            .i_head     (g == 0),
            .i_prev     ((g == 0) ? w_empty : w_slot[(g == 0) ? 0 : g - 1]),
            .i_next     ((g == BOOK_DEPTH - 1) ? w_empty
                         : w_slot[(g == BOOK_DEPTH - 1) ? g : g + 1]),
            .i_prev_hit ((g == 0) ? 1'b0 : w_hit[(g == 0) ? 0 : g - 1]),
            .i_prev_ins ((g == 0) ? 1'b0 : w_ins[(g == 0) ? 0 : g - 1]),
            .o_slot     (w_slot[g]),
            .o_hit      (w_hit[g]),
            .o_ins      (w_ins[g])
        );
    end

    assign o_head  = w_slot[0];
    assign o_found = w_hit[BOOK_DEPTH - 1];
    assign o_full  = w_slot[BOOK_DEPTH - 1].valid;
endmodule

/* src/price_time_order_matching_core.sv */
// price-time priority order matching core, top level
// depends on ptom_pkg and ptom_side
//
// requests enter on s_axis: tdata holds command, order_id, side, order_type,
// limit_price, order_quantity from the lowest bit up
// results leave on m_axis: tuser is kind, tdata holds status, buy_id,
// sell_id, fill_quantity, buy_price, sell_price; tlast marks the done item
// of each request
// each side of the book is a row of BOOK_DEPTH cells; id lookup is one
// compare per cell, combinational; insert and remove shift the row
// an add that reaches matching goes from accept to the next accept through
// search, check, match (one pass per fill and one to leave), rest, done, idle;
// a rejected add goes through search, check, done, idle and a cancel or
// unknown id through search, done, idle; the done item is registered in
// the done state, the trade items in the match state
// a stalled receiver holds the output register and the sequencer waits
// reset empties both sides and drops any request in flight
`timescale 1ns / 1ps
module price_time_order_matching_core
    import ptom_pkg::*;
#(
    parameter int BOOK_DEPTH = BookDepth
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command, order_id, side, order_type, limit_price, order_quantity
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, buy_id, sell_id, fill_quantity, buy_price, sell_price
    output logic [167:0] m_axis_tdata,
    // kind
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);
    t_state r_state, n_state;
    logic [1:0]  r_cmd;
    logic [31:0] r_id, r_price, r_qty;
    logic        r_side, r_fak;
    t_status     r_status;
    logic        r_ovalid;
    logic [167:0] r_odata;
    logic        r_okind, r_olast;

    t_ctl  w_ctl [2];
    t_slot w_head [2];
    logic  w_found [2];
    logic  w_full [2];

    t_slot       w_opp;
    logic        w_cross;
    logic [31:0] w_fill;
    logic        w_out_free;

    for (genvar s = 0; s < 2; s++) begin : g_side
        ptom_side #(.BOOK_DEPTH(BOOK_DEPTH)) u_side (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (w_ctl[s]),
            .o_head (w_head[s]),
            .o_found(w_found[s]),
            .o_full (w_full[s])
        );
    end

    assign w_opp   = r_side ? w_head[0] : w_head[1];
    assign w_cross = w_opp.valid && (r_side ? (r_price <= w_opp.price)
                                            : (r_price >= w_opp.price));
    assign w_fill  = (r_qty < w_opp.qty) ? r_qty : w_opp.qty;
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (s_axis_tvalid) n_state = S_SEARCH;
            S_SEARCH: begin
                if (t_cmd'(r_cmd) == CMD_ADD) begin
                    n_state = S_CHECK;
                end else if (t_cmd'(r_cmd) == CMD_NONE ||
                             !(w_found[0] || w_found[1]) || t_cmd'(r_cmd) == CMD_CANCEL) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_found[0] || w_found[1] || r_qty == '0) n_state = S_DONE;
                else if (r_fak && !w_cross) n_state = S_DONE;
                else if (!r_fak && w_full[r_side]) n_state = S_DONE;
                else n_state = S_MATCH;
            end
            S_MATCH: begin
                if (r_qty == '0 || !w_cross) n_state = S_REST;
            end
            S_REST:  n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            w_ctl[s].op      = OP_HOLD;
            w_ctl[s].is_bid  = (s == 0);
            w_ctl[s].key_id  = r_id;
            w_ctl[s].ins.valid = 1'b1;
            w_ctl[s].ins.id    = r_id;
            w_ctl[s].ins.price = r_price;
            w_ctl[s].ins.qty   = r_qty;
            w_ctl[s].new_qty = w_opp.qty - w_fill;
        end
        case (r_state)
            S_SEARCH: begin
                if (t_cmd'(r_cmd) == CMD_CANCEL || t_cmd'(r_cmd) == CMD_MODIFY) begin
                    w_ctl[0].op = OP_REMOVE;
                    w_ctl[1].op = OP_REMOVE;
                end
            end
            S_MATCH: begin
                if (r_qty != '0 && w_cross && w_out_free) begin
                    w_ctl[!r_side].op = (w_fill == w_opp.qty) ? OP_REMOVE : OP_SETQ0;
                    w_ctl[!r_side].key_id = w_opp.id;
                end
            end
            S_REST: begin
                if (r_qty != '0 && !r_fak) w_ctl[r_side].op = OP_INSERT;
            end
            default: begin
                w_ctl[0].op = OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_MATCH && n_state == S_MATCH && w_out_free) begin
                r_state <= S_MATCH;
            end else if (r_state == S_MATCH && n_state == S_MATCH) begin
                r_state <= S_MATCH;
            end else begin
                r_state <= n_state;
            end
            if (m_axis_tready) r_ovalid <= 1'b0;
            if (r_state == S_MATCH && r_qty != '0 && w_cross && w_out_free) begin
                r_ovalid <= 1'b1;
            end
            if (r_state == S_DONE && w_out_free) r_ovalid <= 1'b1;
        end
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_cmd    <= s_axis_tdata[1:0];
            r_id     <= s_axis_tdata[33:2];
            r_side   <= s_axis_tdata[34];
            r_fak    <= s_axis_tdata[35];
            r_price  <= s_axis_tdata[67:36];
            r_qty    <= s_axis_tdata[99:68];
            r_status <= ST_OK;
        end
        if (r_state == S_SEARCH) begin
            if (t_cmd'(r_cmd) != CMD_ADD && t_cmd'(r_cmd) != CMD_NONE &&
                !(w_found[0] || w_found[1])) r_status <= ST_NOT_FOUND;
        end
        if (r_state == S_CHECK) begin
            if (w_found[0] || w_found[1]) r_status <= ST_DUP_ID;
            else if (r_qty == '0) r_status <= ST_OK;
            else if (r_fak && !w_cross) r_status <= ST_FAK_UNMAT;
            else if (!r_fak && w_full[r_side]) r_status <= ST_SIDE_FULL;
        end
        if (r_state == S_MATCH && r_qty != '0 && w_cross && w_out_free) begin
            r_qty   <= r_qty - w_fill;
            r_okind <= 1'b0;
            r_olast <= 1'b0;
            r_odata <= {5'd0,
                        r_side ? r_price : w_opp.price,
                        r_side ? w_opp.price : r_price,
                        w_fill,
                        r_side ? r_id : w_opp.id,
                        r_side ? w_opp.id : r_id,
                        ST_OK};
        end
        if (r_state == S_DONE && w_out_free) begin
            r_okind <= 1'b1;
            r_olast <= 1'b1;
            r_odata <= {165'd0, r_status};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

    a_tlast_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
        else $error("tlast must mark done items only");
    a_trade_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[2:0] == ST_OK))
        else $error("trade item with nonzero status");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accepted a second request while busy");
endmodule
